>>> rtl/core/apd_pkg.sv
package apd_pkg;

    localparam int FRAC_BITS_DEF = 16;
    localparam int MAX_STEPS_DEF = 4096;

    // shared multiplier operand and product widths
    localparam int MUL_AW = 36;
    localparam int MUL_BW = 33;
    localparam int MUL_PW = MUL_AW + MUL_BW;

    localparam int SUM_W  = 36;
    localparam int WIDE_W = 72;
    localparam int DIV3_DIGITS = 8;

    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 31;
    localparam logic [CFG_IDX_W-1:0] CFG_DRAG_AREA = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_MASS      = 1'b1;
    localparam logic [CFG_DATA_W-1:0] CFG_RESET_VAL = 31'd65536;

    typedef struct packed {
        logic signed [31:0] start_time;
        logic signed [31:0] altitude;
        logic signed [31:0] vert_velocity;
        logic signed [31:0] horiz_velocity;
        logic [23:0]        drag_coeff;
    } t_in;

    typedef struct packed {
        logic signed [31:0] apogee;
        logic               step_limit_hit;
    } t_out;

    localparam logic signed [WIDE_W-1:0] S32_MAX = 72'sd2147483647;
    localparam logic signed [WIDE_W-1:0] S32_MIN = -72'sd2147483648;

    function automatic logic signed [31:0] sat32(input logic signed [WIDE_W-1:0] v);
        logic signed [31:0] r;
        if (v > S32_MAX) begin
            r = 32'sh7FFF_FFFF;
        end else if (v < S32_MIN) begin
            r = 32'sh8000_0000;
        end else begin
            r = 32'(v);
        end
        return r;
    endfunction

endpackage

>>> rtl/core/apd_mul.sv
module apd_mul import apd_pkg::*; (
    input  logic                     i_clk,
    input  logic signed [MUL_AW-1:0] i_a,
    input  logic signed [MUL_BW-1:0] i_b,
    output logic signed [MUL_PW-1:0] o_p
);

    logic signed [MUL_PW-1:0] r_p;

    // one signed multiply, product registered
    always_ff @(posedge i_clk) begin
        r_p <= MUL_PW'(i_a) * MUL_PW'(i_b);
    end

    assign o_p = r_p;

endmodule

>>> rtl/core/apd_kdiv.sv
module apd_kdiv import apd_pkg::*; #(
    parameter int DW = 55 + FRAC_BITS_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    input  logic [DW-1:0] i_dividend,
    input  logic [31:0]   i_divisor,
    output logic          o_done,
    output logic [DW-1:0] o_quot
);

    localparam int CW = $clog2(DW + 1);

    logic [DW-1:0] r_q;
    logic [31:0]   r_rem;
    logic [31:0]   r_div;
    logic [CW-1:0] r_cnt;
    logic          r_busy;
    logic          r_done;
    logic [32:0]   w_rr;
    logic          w_ge;

    // restoring division, one quotient bit per cycle
    assign w_rr = {r_rem, r_q[DW-1]};
    assign w_ge = w_rr >= {1'b0, r_div};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_q    <= i_dividend;
                r_rem  <= '0;
                r_div  <= i_divisor;
                r_cnt  <= CW'(DW);
                r_busy <= 1'b1;
            end else if (r_busy) begin
                r_rem <= w_ge ? 32'(w_rr - {1'b0, r_div}) : w_rr[31:0];
                r_q   <= {r_q[DW-2:0], w_ge};
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CW'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_quot = r_q;

endmodule

>>> rtl/core/apd_div3.sv
module apd_div3 import apd_pkg::*; #(
    parameter int W = MUL_PW
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_start,
    input  logic [W-1:0] i_val,
    output logic         o_done,
    output logic [W-1:0] o_quot
);

    localparam int CH = (W + DIV3_DIGITS - 1) / DIV3_DIGITS;
    localparam int PW = CH * DIV3_DIGITS;
    localparam int CW = $clog2(CH + 1);

    logic [PW-1:0]          r_val;
    logic [PW-1:0]          r_q;
    logic [1:0]             r_rem;
    logic [CW-1:0]          r_cnt;
    logic                   r_busy;
    logic                   r_done;
    logic [DIV3_DIGITS-1:0] w_chunk;
    logic [1:0]             w_rem;

    // divide by three, DIV3_DIGITS quotient bits at a time
    always_comb begin
        logic [2:0] rr;
        logic [1:0] rem;
        rem = r_rem;
        for (int i = 0; i < DIV3_DIGITS; i++) begin
            rr = {rem, r_val[PW-1-i]};
            if (rr >= 3'd3) begin
                w_chunk[DIV3_DIGITS-1-i] = 1'b1;
                rem = 2'(rr - 3'd3);
            end else begin
                w_chunk[DIV3_DIGITS-1-i] = 1'b0;
                rem = rr[1:0];
            end
        end
        w_rem = rem;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_val  <= PW'(i_val);
                r_rem  <= '0;
                r_cnt  <= CW'(CH);
                r_busy <= 1'b1;
            end else if (r_busy) begin
                r_val <= r_val << DIV3_DIGITS;
                r_q   <= {r_q[PW-DIV3_DIGITS-1:0], w_chunk};
                r_rem <= w_rem;
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CW'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_quot = r_q[W-1:0];

endmodule

>>> rtl/core/apogee_predictor_rk4_drag.sv
// Apogee predictor. Pulse start while busy is low to hand in one item (start time,
// altitude, vertical and horizontal velocity, drag coefficient); busy then stays high
// until the result is out. The result shows on o_result for exactly one cycle with
// o_valid high and cannot be held off, so capture it in that cycle. The block first
// forms the drag constant with a serial divider, then runs RK4 steps of 0.1 s:
// every multiply of the step (squares, four partial products per drag term, step
// scaling) shares one 36x33 multiplier, and the three sixth-step divisions use a
// divide-by-three unit at 8 bits per cycle. The number of steps is capped at MAX_STEPS.
// Write configuration only while busy is low.
module apogee_predictor_rk4_drag import apd_pkg::*; #(
    parameter int FRAC_BITS = FRAC_BITS_DEF,
    parameter int MAX_STEPS = MAX_STEPS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  start,
    output logic                  busy,
    input  t_in                   i_item,
    output logic                  o_valid,
    output t_out                  o_result,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    localparam longint ONE_L  = longint'(1) << FRAC_BITS;
    localparam longint H_L    = (ONE_L + 5) / 10;
    localparam longint G_L    = (981 * ONE_L + 50) / 100;
    localparam longint TEPS_L = (ONE_L + 500) / 1000;
    localparam int     KW     = 55 + FRAC_BITS;
    localparam int     SW     = $clog2(MAX_STEPS + 1);
    localparam logic signed [31:0]     TEPS_Q = 32'(TEPS_L);
    localparam logic signed [MUL_BW-1:0] H_B  = MUL_BW'(H_L);

    typedef enum logic [4:0] {
        S_IDLE, S_KMUL, S_KDIV_GO, S_KDIV, S_CHECK, S_STEP,
        S_SQ, S_V2, S_PP0, S_PP1, S_PP2, S_PP3, S_PP4, S_ACC,
        S_AMUL, S_ASH, S_FMUL, S_FDIV_GO, S_FDIV, S_TADV
    } t_state;

    t_state r_state;

    logic [CFG_DATA_W-1:0] r_daf;
    logic [CFG_DATA_W-1:0] r_mass;
    logic [23:0]           r_cd;
    logic signed [31:0]    r_t, r_x, r_vz, r_vx;
    logic signed [31:0]    r_cvz, r_cvx, r_cur;
    logic signed [SUM_W-1:0] r_sv, r_saz, r_sax;
    logic [62:0]           r_k2;
    logic [63:0]           r_v2;
    logic [127:0]          r_acc;
    logic [1:0]            r_stage;
    logic                  r_axis;
    logic [1:0]            r_fin;
    logic                  r_yneg;
    logic [SW-1:0]         r_steps;
    logic                  r_valid;
    logic signed [31:0]    r_apogee;
    logic                  r_limit;

    logic signed [MUL_AW-1:0] w_mul_a;
    logic signed [MUL_BW-1:0] w_mul_b;
    logic signed [MUL_PW-1:0] m_p;

    logic          kd_start, kd_done;
    logic [KW-1:0] kd_quot;
    logic [30:0]   w_m;

    logic              d3_start, d3_done;
    logic [MUL_PW-1:0] d3_quot;
    logic [MUL_PW-1:0] w_u;

    logic signed [31:0]       w_cv;
    logic [32:0]              w_abs_ext;
    logic [31:0]              w_abs;
    logic [63:0]              w_dfull;
    logic [31:0]              w_d;
    logic signed [31:0]       w_accel;
    logic signed [SUM_W-1:0]  w_wa, w_wv;
    logic                     w_dbl;
    logic signed [MUL_PW-1:0] w_y_adv, w_y_fin;
    logic signed [31:0]       w_base_adv, w_base_fin, w_new_adv, w_new_fin;
    logic signed [MUL_PW:0]   w_q;
    logic signed [SUM_W-1:0]  w_fsum;
    logic                     w_more;

    apd_mul u_mul (
        .i_clk (i_clk),
        .i_a   (w_mul_a),
        .i_b   (w_mul_b),
        .o_p   (m_p)
    );

    apd_kdiv #(.DW(KW)) u_kdiv (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (kd_start),
        .i_dividend ({m_p[54:0], {FRAC_BITS{1'b0}}}),
        .i_divisor  ({w_m, 1'b0}),
        .o_done     (kd_done),
        .o_quot     (kd_quot)
    );

    apd_div3 #(.W(MUL_PW)) u_div3 (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (d3_start),
        .i_val   (w_u),
        .o_done  (d3_done),
        .o_quot  (d3_quot)
    );

    // zero mass counts as one LSB
    assign w_m = (r_mass == '0) ? 31'd1 : r_mass;

    // magnitude of the velocity whose drag is being formed
    assign w_cv      = r_axis ? r_cvx : r_cvz;
    assign w_abs_ext = w_cv[31] ? -{w_cv[31], w_cv} : {w_cv[31], w_cv};
    assign w_abs     = w_abs_ext[31:0];

    // drag magnitude from the full K*v^2 product, capped at 2^31 LSB
    assign w_dfull = r_acc[63:0] >> (2 * FRAC_BITS);
    assign w_d     = ((|r_acc[127:64]) || (w_dfull > 64'h8000_0000)) ? 32'h8000_0000
                                                                      : w_dfull[31:0];
    assign w_accel = r_axis ? sat32(-WIDE_W'($signed({1'b0, w_d})))
                            : sat32(-WIDE_W'($signed({1'b0, w_d})) - WIDE_W'(G_L));

    // RK4 weights 1, 2, 2, 1
    assign w_dbl = (r_stage == 2'd1) || (r_stage == 2'd2);
    assign w_wa  = w_dbl ? (SUM_W'(w_accel) <<< 1) : SUM_W'(w_accel);
    assign w_wv  = w_dbl ? (SUM_W'(r_cvz) <<< 1) : SUM_W'(r_cvz);

    // stage velocity: half step for the first two, full step for the third
    assign w_y_adv    = (r_stage == 2'd2) ? (m_p >>> FRAC_BITS) : (m_p >>> (FRAC_BITS + 1));
    assign w_base_adv = r_axis ? r_vx : r_vz;
    assign w_new_adv  = sat32(WIDE_W'(w_base_adv) + WIDE_W'(w_y_adv));

    // sixth step: halve by shift, then divide by three on the magnitude so that the signed result rounds down
    assign w_y_fin = m_p >>> (FRAC_BITS + 1);
    assign w_u     = w_y_fin[MUL_PW-1] ? MUL_PW'(-w_y_fin + MUL_PW'(2)) : MUL_PW'(w_y_fin);
    assign w_q     = r_yneg ? -$signed({1'b0, d3_quot}) : $signed({1'b0, d3_quot});

    always_comb begin
        case (r_fin)
            2'd0:    w_base_fin = r_x;
            2'd1:    w_base_fin = r_vz;
            default: w_base_fin = r_vx;
        endcase
        case (r_fin)
            2'd0:    w_fsum = r_sv;
            2'd1:    w_fsum = r_saz;
            default: w_fsum = r_sax;
        endcase
    end
    assign w_new_fin = sat32(WIDE_W'(w_base_fin) + WIDE_W'(w_q));

    assign w_more = (r_t < TEPS_Q) || (r_vz > 32'sd0);

    assign kd_start = (r_state == S_KDIV_GO);
    assign d3_start = (r_state == S_FDIV_GO);

    // multiplier operands by sequencer state
    always_comb begin
        w_mul_a = '0;
        w_mul_b = '0;
        case (r_state)
            S_KMUL: begin
                w_mul_a = MUL_AW'({1'b0, r_daf});
                w_mul_b = MUL_BW'({1'b0, r_cd});
            end
            S_SQ: begin
                w_mul_a = MUL_AW'({1'b0, w_abs});
                w_mul_b = MUL_BW'({1'b0, w_abs});
            end
            S_PP0: begin
                w_mul_a = MUL_AW'({1'b0, r_k2[31:0]});
                w_mul_b = MUL_BW'({1'b0, r_v2[31:0]});
            end
            S_PP1: begin
                w_mul_a = MUL_AW'({1'b0, r_k2[31:0]});
                w_mul_b = MUL_BW'({1'b0, r_v2[63:32]});
            end
            S_PP2: begin
                w_mul_a = MUL_AW'({1'b0, r_k2[62:32]});
                w_mul_b = MUL_BW'({1'b0, r_v2[31:0]});
            end
            S_PP3: begin
                w_mul_a = MUL_AW'({1'b0, r_k2[62:32]});
                w_mul_b = MUL_BW'({1'b0, r_v2[63:32]});
            end
            S_AMUL: begin
                w_mul_a = MUL_AW'(r_cur);
                w_mul_b = H_B;
            end
            S_FMUL: begin
                w_mul_a = MUL_AW'(w_fsum);
                w_mul_b = H_B;
            end
            default: begin
                w_mul_a = '0;
                w_mul_b = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_valid <= 1'b0;
            r_daf   <= CFG_RESET_VAL;
            r_mass  <= CFG_RESET_VAL;
        end else begin
            r_valid <= 1'b0;
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_DRAG_AREA: r_daf  <= i_cfg_data;
                    CFG_MASS:      r_mass <= i_cfg_data;
                    default:       r_daf  <= r_daf;
                endcase
            end
            case (r_state)
                S_IDLE: begin
                    // take the item and reset the step count
                    if (start) begin
                        r_t     <= i_item.start_time;
                        r_x     <= i_item.altitude;
                        r_vz    <= i_item.vert_velocity;
                        r_vx    <= i_item.horiz_velocity;
                        r_cd    <= i_item.drag_coeff;
                        r_steps <= '0;
                        r_state <= S_KMUL;
                    end
                end
                S_KMUL:    r_state <= S_KDIV_GO;
                S_KDIV_GO: r_state <= S_KDIV;
                S_KDIV: begin
                    // cap K at 2^62
                    if (kd_done) begin
                        r_k2    <= (kd_quot > (KW'(1) << 62)) ? (63'(1) << 62)
                                                              : kd_quot[62:0];
                        r_state <= S_CHECK;
                    end
                end
                S_CHECK: begin
                    if (w_more && (r_steps < SW'(MAX_STEPS))) begin
                        r_state <= S_STEP;
                    end else begin
                        r_apogee <= r_x;
                        r_limit  <= w_more;
                        r_valid  <= 1'b1;
                        r_state  <= S_IDLE;
                    end
                end
                S_STEP: begin
                    r_cvz   <= r_vz;
                    r_cvx   <= r_vx;
                    r_sv    <= '0;
                    r_saz   <= '0;
                    r_sax   <= '0;
                    r_stage <= 2'd0;
                    r_axis  <= 1'b0;
                    r_state <= S_SQ;
                end
                S_SQ: r_state <= S_V2;
                S_V2: begin
                    r_v2    <= m_p[63:0] >> FRAC_BITS;
                    r_state <= S_PP0;
                end
                S_PP0: r_state <= S_PP1;
                S_PP1: begin
                    r_acc   <= 128'(m_p[63:0]);
                    r_state <= S_PP2;
                end
                S_PP2: begin
                    r_acc   <= r_acc + (128'(m_p[63:0]) << 32);
                    r_state <= S_PP3;
                end
                S_PP3: begin
                    r_acc   <= r_acc + (128'(m_p[63:0]) << 32);
                    r_state <= S_PP4;
                end
                S_PP4: begin
                    r_acc   <= r_acc + (128'(m_p[63:0]) << 64);
                    r_state <= S_ACC;
                end
                S_ACC: begin
                    // fold this stage into the weighted sums
                    r_cur <= w_accel;
                    if (!r_axis) begin
                        r_saz <= r_saz + w_wa;
                        r_sv  <= r_sv + w_wv;
                    end else begin
                        r_sax <= r_sax + w_wa;
                    end
                    if (r_stage == 2'd3) begin
                        if (!r_axis) begin
                            r_axis  <= 1'b1;
                            r_state <= S_SQ;
                        end else begin
                            r_fin   <= 2'd0;
                            r_state <= S_FMUL;
                        end
                    end else begin
                        r_state <= S_AMUL;
                    end
                end
                S_AMUL: r_state <= S_ASH;
                S_ASH: begin
                    // next stage velocity for this axis
                    if (!r_axis) begin
                        r_cvz   <= w_new_adv;
                        r_axis  <= 1'b1;
                    end else begin
                        r_cvx   <= w_new_adv;
                        r_axis  <= 1'b0;
                        r_stage <= r_stage + 2'd1;
                    end
                    r_state <= S_SQ;
                end
                S_FMUL: r_state <= S_FDIV_GO;
                S_FDIV_GO: begin
                    r_yneg  <= w_y_fin[MUL_PW-1];
                    r_state <= S_FDIV;
                end
                S_FDIV: begin
                    // update altitude, then vertical, then horizontal velocity
                    if (d3_done) begin
                        case (r_fin)
                            2'd0:    r_x  <= w_new_fin;
                            2'd1:    r_vz <= w_new_fin;
                            default: r_vx <= w_new_fin;
                        endcase
                        if (r_fin == 2'd2) begin
                            r_state <= S_TADV;
                        end else begin
                            r_fin   <= r_fin + 2'd1;
                            r_state <= S_FMUL;
                        end
                    end
                end
                S_TADV: begin
                    r_t     <= sat32(WIDE_W'(r_t) + WIDE_W'(H_L));
                    r_steps <= r_steps + 1'b1;
                    r_state <= S_CHECK;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign busy                    = (r_state != S_IDLE);
    assign o_valid                 = r_valid;
    assign o_result.apogee         = r_apogee;
    assign o_result.step_limit_hit = r_limit;

endmodule
